[sv/ddo_pkg.sv]
// Shared types and constants for the differential-drive odometry block.
package ddo_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_LINEAR_GAIN  = 2'd0;
   localparam logic [1:0] REG_ANGULAR_GAIN = 2'd1;
   localparam logic [1:0] REG_TWIST_SIGN   = 2'd2;

   // Fixed-point constants.
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [31:0] CORDIC_START = 32'sd163008219;
   localparam logic signed [31:0] TICK_Q32     = 32'sd42949673;
   localparam logic signed [31:0] HEAD_Q32     = 32'sd6835653;

   // Arctangent of 2^-i as a binary angle, 2^32 per turn.
   localparam logic [29:0] ARC_TABLE [0:CORDIC_STEPS-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10680862,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   // Operand selection for the shared multiplier.
   typedef enum logic [2:0] {
      MUL_LIN,
      MUL_ANG,
      MUL_TICK,
      MUL_HEAD,
      MUL_X,
      MUL_Y
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        cap_speed;
      logic        cap_omega;
      logic        cap_ds;
      logic        cordic_init;
      logic        cordic_step;
      logic        upd_x;
      logic        upd_y;
      logic        load_out;
   } ddo_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cordic_last;
   } ddo_status_type;

endpackage

[sv/ddo_req_if.sv]
// Input channel interface: one pair of wheel speed counts per word.
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;

   modport source (output valid, output left_speed, output right_speed, input ready);
   modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

[sv/ddo_rsp_if.sv]
// Result channel interface: pose and twist per word.
interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic [15:0]        heading;
   logic signed [31:0] linear_speed;
   logic signed [31:0] turn_rate;

   modport source (output valid, output position_x, output position_y, output heading,
                   output linear_speed, output turn_rate, input ready);
   modport sink   (input valid, input position_x, input position_y, input heading,
                   input linear_speed, input turn_rate, output ready);
endinterface

[sv/ddo_ctrl.sv]
// Sequencing state machine for the odometry datapath.
module ddo_ctrl import ddo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ddo_cmd_type    cmd,
   input  ddo_status_type status
);

   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_MUL_LIN     = 4'd1;
   localparam logic [3:0] ST_MUL_ANG     = 4'd2;
   localparam logic [3:0] ST_MUL_TICK    = 4'd3;
   localparam logic [3:0] ST_MUL_HEAD    = 4'd4;
   localparam logic [3:0] ST_CORDIC_INIT = 4'd5;
   localparam logic [3:0] ST_CORDIC      = 4'd6;
   localparam logic [3:0] ST_MUL_X       = 4'd7;
   localparam logic [3:0] ST_MUL_Y       = 4'd8;
   localparam logic [3:0] ST_UPD_Y       = 4'd9;
   localparam logic [3:0] ST_DONE        = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_LIN;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_LIN;
            end
         end
         ST_MUL_LIN: begin
            cmd.mul_sel = MUL_LIN;
            state_in    = ST_MUL_ANG;
         end
         ST_MUL_ANG: begin
            cmd.cap_speed = 1'b1;
            cmd.mul_sel   = MUL_ANG;
            state_in      = ST_MUL_TICK;
         end
         ST_MUL_TICK: begin
            cmd.cap_omega = 1'b1;
            cmd.mul_sel   = MUL_TICK;
            state_in      = ST_MUL_HEAD;
         end
         ST_MUL_HEAD: begin
            cmd.cap_ds  = 1'b1;
            cmd.mul_sel = MUL_HEAD;
            state_in    = ST_CORDIC_INIT;
         end
         ST_CORDIC_INIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            cmd.mul_sel = MUL_X;
            state_in    = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.upd_x   = 1'b1;
            cmd.mul_sel = MUL_Y;
            state_in    = ST_UPD_Y;
         end
         ST_UPD_Y: begin
            cmd.upd_y = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output word stays valid until it is taken.
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   // The rotation loop leaves for the position multiply after its last step.
   a_cordic_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && status.cordic_last) |=> (state_ff == ST_MUL_X))
      else $error("rotation loop did not exit");

   // An accepted word starts the multiply sequence.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL_LIN))
      else $error("accepted word did not start work");

endmodule

[sv/ddo_datapath.sv]
// Odometry datapath: shared multiplier, rotation unit and pose registers.
module ddo_datapath import ddo_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  ddo_cmd_type        cmd,
   output ddo_status_type     status,
   input  logic signed [15:0] left_speed,
   input  logic signed [15:0] right_speed,
   input  logic [23:0]        linear_gain,
   input  logic [23:0]        angular_gain,
   input  logic               twist_sign,
   output logic signed [31:0] position_x,
   output logic signed [31:0] position_y,
   output logic [15:0]        heading,
   output logic signed [31:0] linear_speed,
   output logic signed [31:0] turn_rate
);

   localparam int SW = ((POSITION_BITS > 30) ? POSITION_BITS : 30) + 1;
   localparam int OW = (POSITION_BITS > 32) ? POSITION_BITS : 32;
   localparam int HALF_SH  = 49 - ANGLE_BITS;
   localparam int DELTA_SH = 48 - ANGLE_BITS;
   localparam logic signed [65:0] HALF_RND  = 66'sd1 <<< (HALF_SH - 1);
   localparam logic signed [65:0] DELTA_RND = 66'sd1 <<< (DELTA_SH - 1);
   localparam logic signed [SW-1:0] PMAX = (SW'(1) <<< (POSITION_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
   localparam logic signed [OW-1:0] OMAX = OW'(64'sd2147483647);
   localparam logic signed [OW-1:0] OMIN = OW'(-64'sd2147483648);

   // Saturate a wide value to 32-bit signed.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Clamp a pose sum to the pose range.
   function automatic logic signed [POSITION_BITS-1:0] sat_pose(input logic signed [SW-1:0] v);
      logic signed [POSITION_BITS-1:0] r;
      if (v > PMAX) begin
         r = PMAX[POSITION_BITS-1:0];
      end else if (v < PMIN) begin
         r = PMIN[POSITION_BITS-1:0];
      end else begin
         r = v[POSITION_BITS-1:0];
      end
      return r;
   endfunction

   // Clamp a pose to the 32-bit output range.
   function automatic logic signed [31:0] sat_out(input logic signed [POSITION_BITS-1:0] p);
      logic signed [OW-1:0] v;
      logic signed [31:0]   r;
      v = OW'(p);
      if (v > OMAX) begin
         r = 32'sh7fffffff;
      end else if (v < OMIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [15:0] left_ff, right_ff;
   logic signed [16:0] sum_w, diff_w;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [65:0] prod_ff;
   logic signed [31:0] speed_ff, omega_ff, rep_w;
   logic signed [33:0] ds_ff;
   logic signed [65:0] speed_rnd, omega_rnd, ds_rnd, half_rnd, delta_rnd, dx_rnd;
   logic [ANGLE_BITS-1:0] delta_ff, half_w, mid_w;
   logic [31:0]        ang_w;
   logic               flip_w, flip_ff;
   logic signed [31:0] x_ff, y_ff, xs_w, ys_w, cos_w, sin_w;
   logic signed [33:0] z_ff, arc_w;
   logic [4:0]         cnt_ff;
   logic signed [29:0] dpos_w;
   logic signed [SW-1:0] sum_x_w, sum_y_w;
   logic signed [POSITION_BITS-1:0] pose_x_ff, pose_y_ff;
   logic [ANGLE_BITS-1:0] pose_h_ff;
   logic [31:0]        head32_w;

   assign sum_w  = 17'(left_ff) + 17'(right_ff);
   assign diff_w = 17'(right_ff) - 17'(left_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_LIN: begin
            mul_a = 34'(sum_w);
            mul_b = $signed({8'b0, linear_gain});
         end
         MUL_ANG: begin
            mul_a = 34'(diff_w);
            mul_b = $signed({8'b0, angular_gain});
         end
         MUL_TICK: begin
            mul_a = 34'(speed_ff);
            mul_b = TICK_Q32;
         end
         MUL_HEAD: begin
            mul_a = 34'(omega_ff);
            mul_b = HEAD_Q32;
         end
         MUL_X: begin
            mul_a = ds_ff;
            mul_b = cos_w;
         end
         MUL_Y: begin
            mul_a = ds_ff;
            mul_b = sin_w;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Rounded views of the registered product.
   assign speed_rnd = (prod_ff + 66'sd128) >>> 8;
   assign omega_rnd = speed_rnd;
   assign ds_rnd    = (prod_ff + (66'sd1 <<< 23)) >>> 24;
   assign half_rnd  = (prod_ff + HALF_RND) >>> HALF_SH;
   assign delta_rnd = (prod_ff + DELTA_RND) >>> DELTA_SH;
   assign dx_rnd    = (prod_ff + (66'sd1 <<< 35)) >>> 36;
   assign dpos_w    = dx_rnd[29:0];

   // Midpoint heading folded into the right half plane.
   assign half_w = half_rnd[ANGLE_BITS-1:0];
   assign mid_w  = pose_h_ff + half_w;
   assign ang_w  = {mid_w, {(32 - ANGLE_BITS){1'b0}}};
   assign flip_w = ang_w[31] ^ ang_w[30];

   // One rotation step.
   assign xs_w  = x_ff >>> cnt_ff;
   assign ys_w  = y_ff >>> cnt_ff;
   assign arc_w = 34'(ARC_TABLE[cnt_ff]);
   assign cos_w = flip_ff ? -x_ff : x_ff;
   assign sin_w = flip_ff ? -y_ff : y_ff;
   assign status.cordic_last = (cnt_ff == 5'(CORDIC_STEPS - 1));

   assign sum_x_w = SW'(pose_x_ff) + SW'(dpos_w);
   assign sum_y_w = SW'(pose_y_ff) + SW'(dpos_w);

   // Reported turn rate, negated on request without wrapping.
   always_comb begin
      if (!twist_sign) begin
         rep_w = omega_ff;
      end else if (omega_ff == 32'sh80000000) begin
         rep_w = 32'sh7fffffff;
      end else begin
         rep_w = -omega_ff;
      end
   end

   assign head32_w = {pose_h_ff, {(32 - ANGLE_BITS){1'b0}}};

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load_in) begin
         left_ff  <= left_speed;
         right_ff <= right_speed;
      end
      if (cmd.cap_speed) begin
         speed_ff <= sat32(speed_rnd);
      end
      if (cmd.cap_omega) begin
         omega_ff <= sat32(omega_rnd);
      end
      if (cmd.cap_ds) begin
         ds_ff <= ds_rnd[33:0];
      end
      if (cmd.cordic_init) begin
         delta_ff <= delta_rnd[ANGLE_BITS-1:0];
         flip_ff  <= flip_w;
         x_ff     <= CORDIC_START;
         y_ff     <= '0;
         z_ff     <= 34'($signed({ang_w[31] ^ flip_w, ang_w[30:0]}));
      end else if (cmd.cordic_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys_w;
            y_ff <= y_ff + xs_w;
            z_ff <= z_ff - arc_w;
         end else begin
            x_ff <= x_ff + ys_w;
            y_ff <= y_ff - xs_w;
            z_ff <= z_ff + arc_w;
         end
      end
      if (cmd.load_out) begin
         position_x   <= sat_out(pose_x_ff);
         position_y   <= sat_out(pose_y_ff);
         heading      <= head32_w[31:16];
         linear_speed <= speed_ff;
         turn_rate    <= rep_w;
      end
   end

   // Iteration counter and pose state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
      end else begin
         if (cmd.cordic_init) begin
            cnt_ff <= '0;
         end else if (cmd.cordic_step) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
         if (cmd.upd_x) begin
            pose_x_ff <= sat_pose(sum_x_w);
         end
         if (cmd.upd_y) begin
            pose_y_ff <= sat_pose(sum_y_w);
            pose_h_ff <= pose_h_ff + delta_ff;
         end
      end
   end

   // The rotation starts from step zero.
   a_cnt_start: assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_init |=> (cnt_ff == 5'd0))
      else $error("rotation counter not cleared");

   // Steps never run past the table.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_step |-> (cnt_ff < 5'(CORDIC_STEPS)))
      else $error("rotation step beyond table");

   // The heading only moves with the y update.
   a_heading_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.upd_y) && !$past(reset) |-> $stable(pose_h_ff))
      else $error("heading changed outside update");

endmodule

[sv/differential_drive_odometry.sv]
// Differential-drive odometry: each word of wheel speed counts yields one word
// of pose and twist. After acceptance, a word takes four passes through one
// shared multiplier for speed, turn rate, displacement and heading increment,
// a load of the rotation unit, 24 iterations of the rotation unit for cosine
// and sine of the midpoint heading, two more multiplier passes for the x and
// y steps, the y update and a load of the output register. One word is worked
// on at a time; the next is accepted in the cycle after the result is loaded.
// A result that is still waiting in the output register holds the next one
// back until it is taken. Position saturates to POSITION_BITS and is reported
// saturated to 32 bits; heading wraps at 2^ANGLE_BITS and is reported as a
// 16-bit binary angle.
module differential_drive_odometry import ddo_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   ddo_req_if.sink                  req,
   ddo_rsp_if.source                rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [23:0] linear_gain_ff;
   logic [23:0] angular_gain_ff;
   logic        twist_sign_ff;
   logic        csr_write;
   logic [1:0]  reg_index;
   ddo_cmd_type    cmd;
   ddo_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff  <= 24'd10155;
         angular_gain_ff <= 24'd25842;
         twist_sign_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_LINEAR_GAIN:  linear_gain_ff  <= csr_pwdata[23:0];
            REG_ANGULAR_GAIN: angular_gain_ff <= csr_pwdata[23:0];
            REG_TWIST_SIGN:   twist_sign_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_index)
         REG_LINEAR_GAIN:  csr_prdata = {8'b0, linear_gain_ff};
         REG_ANGULAR_GAIN: csr_prdata = {8'b0, angular_gain_ff};
         REG_TWIST_SIGN:   csr_prdata = {31'b0, twist_sign_ff};
         default:          csr_prdata = '0;
      endcase
   end

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ddo_datapath #(
      .ANGLE_BITS    (ANGLE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .left_speed   (req.left_speed),
      .right_speed  (req.right_speed),
      .linear_gain  (linear_gain_ff),
      .angular_gain (angular_gain_ff),
      .twist_sign   (twist_sign_ff),
      .position_x   (rsp.position_x),
      .position_y   (rsp.position_y),
      .heading      (rsp.heading),
      .linear_speed (rsp.linear_speed),
      .turn_rate    (rsp.turn_rate)
   );

endmodule
